// ===== hdl/ctf_pkg.sv =====
// Shared types, constants and the arctangent table of the complementary tilt filter.
`default_nettype none

package ctf_pkg;

  // CORDIC configuration
  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int CordicIters = (CordicSteps > TableLen) ? TableLen : CordicSteps;
  localparam int IterW       = $clog2(CordicIters);

  // Datapath widths
  localparam int CordicW = 32;   // x and y of the rotation
  localparam int ZW      = 33;   // angle accumulator, 2^-16 of 1/128 degree
  localparam int MulW    = 18;   // operand width of the shared multiplier
  localparam int ProdW   = 2 * MulW;
  localparam int DiffW   = 34;
  localparam int SumW    = 53;
  localparam int CfgIdxW = 8;

  localparam logic signed [ZW-1:0] HalfTurn    = 33'sd1509949440;
  localparam logic signed [15:0]   AngleLimit  = 16'sd23040;
  localparam logic [15:0]          AlphaReset  = 16'd64225;
  localparam logic [15:0]          GainReset   = 16'd734;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_ALPHA = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN  = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_ANGLE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DONE
  } ctf_state_t;

  typedef struct packed {
    logic load;     // latch a sample and prerotate
    logic iter;     // one CORDIC micro-rotation
    logic angle;    // round and clamp the angle, multiply rate by gain
    logic diff;     // form predicted minus accelerometer angle
    logic mul_lo;   // alpha times low half of the difference
    logic mul_hi;   // alpha times high half of the difference
    logic finish;   // combine, saturate, write back and present
  } ctf_cmd_t;

  typedef struct packed {
    logic out_busy; // result register full and not taken this cycle
  } ctf_status_t;

  // round(atan(2^-i) in degrees * 2^23)
  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 33'sd377487360;
      5'd1:  v = 33'sd222843801;
      5'd2:  v = 33'sd117744544;
      5'd3:  v = 33'sd59768969;
      5'd4:  v = 33'sd30000467;
      5'd5:  v = 33'sd15014858;
      5'd6:  v = 33'sd7509261;
      5'd7:  v = 33'sd3754860;
      5'd8:  v = 33'sd1877459;
      5'd9:  v = 33'sd938733;
      5'd10: v = 33'sd469367;
      5'd11: v = 33'sd234683;
      5'd12: v = 33'sd117342;
      5'd13: v = 33'sd58671;
      5'd14: v = 33'sd29335;
      5'd15: v = 33'sd14668;
      5'd16: v = 33'sd7334;
      5'd17: v = 33'sd3667;
      5'd18: v = 33'sd1833;
      5'd19: v = 33'sd917;
      5'd20: v = 33'sd458;
      5'd21: v = 33'sd229;
      5'd22: v = 33'sd115;
      5'd23: v = 33'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ctf_ctrl.sv =====
// Sequencer of the complementary tilt filter: walks one sample through the datapath.
`default_nettype none

module ctf_ctrl
  import ctf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire ctf_status_t status,
  output ctf_cmd_t         cmd,
  output logic [IterW-1:0] iter_idx
);

  ctf_state_t       state, state_next;
  logic [IterW-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd.iter   = 1'b1;
        count_next = count + 1'b1;
        if (count == IterW'(CordicIters - 1)) begin
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.angle  = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register can take the new result
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign iter_idx = count;

endmodule

`default_nettype wire

// ===== hdl/ctf_datapath.sv =====
// Datapath of the complementary tilt filter: CORDIC, shared multiplier, blend and result.
`default_nettype none

module ctf_datapath
  import ctf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctf_cmd_t           cmd,
  input  wire logic [IterW-1:0]   iter_idx,
  output ctf_status_t             status,
  input  wire logic [47:0]        s_tdata,
  input  wire logic               cfg_valid,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [31:0]             m_tdata
);

  logic [15:0] alpha;
  logic [15:0] gyro_step_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha          <= AlphaReset;
      gyro_step_gain <= GainReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA: alpha          <= cfg_data;
        CFG_GAIN:  gyro_step_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample unpacking: drop the four unused low bits of the accelerometer words
  logic signed [15:0]        rate_in;
  logic signed [11:0]        ax_in, az_in;
  logic signed [CordicW-1:0] x0, y0;

  assign rate_in = s_tdata[15:0];
  assign ax_in   = s_tdata[31:20];
  assign az_in   = s_tdata[47:36];
  assign x0      = {{(CordicW - 28){az_in[11]}}, az_in, 16'b0};
  assign y0      = {{(CordicW - 28){ax_in[11]}}, ax_in, 16'b0};

  logic signed [CordicW-1:0] x, y;
  logic signed [ZW-1:0]      z;
  logic                      zero_vec;
  logic signed [15:0]        rate;

  logic signed [CordicW-1:0] dx, dy;
  logic signed [ZW-1:0]      dz;

  assign dx = y >>> iter_idx;
  assign dy = x >>> iter_idx;
  assign dz = atan_step(5'(iter_idx));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate     <= rate_in;
      zero_vec <= (ax_in == 12'sd0) && (az_in == 12'sd0);
      if (az_in[11]) begin
        // turn the vector by a half turn into the right half plane
        x <= -x0;
        y <= -y0;
        z <= ax_in[11] ? -HalfTurn : HalfTurn;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (cmd.iter) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end
    end
  end

  // Round the accumulator to 1/128 degree and clamp
  logic signed [ZW-1:0]   z_rnd;
  logic signed [ZW-17:0]  z_q;
  logic signed [15:0]     z_clamp;

  assign z_rnd = z + ZW'(32768);
  assign z_q   = z_rnd[ZW-1:16];

  always_comb begin
    if (z_q > 17'(AngleLimit)) begin
      z_clamp = AngleLimit;
    end else if (z_q < -17'(AngleLimit)) begin
      z_clamp = -AngleLimit;
    end else begin
      z_clamp = z_q[15:0];
    end
  end

  // Shared 18x18 multiplier
  logic signed [15:0]      acc;
  logic signed [32:0]      prod;
  logic signed [DiffW-1:0] d;
  logic [31:0]             p_lo;
  logic signed [34:0]      p_hi;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [15:0]      est;

  always_comb begin
    if (cmd.angle) begin
      mul_a = {{(MulW - 16){rate[15]}}, rate};
      mul_b = {{(MulW - 16){1'b0}}, gyro_step_gain};
    end else if (cmd.mul_lo) begin
      mul_a = {{(MulW - 16){1'b0}}, alpha};
      mul_b = {{(MulW - 16){1'b0}}, d[15:0]};
    end else begin
      mul_a = {{(MulW - 16){1'b0}}, alpha};
      mul_b = d[DiffW-1:16];
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      acc  <= zero_vec ? 16'sd0 : z_clamp;
      prod <= mul_p[32:0];
    end
    if (cmd.diff) begin
      d <= {{(DiffW - 32){est[15]}}, est, 16'b0}
         + {{(DiffW - 33){prod[32]}}, prod}
         - {{(DiffW - 32){acc[15]}}, acc, 16'b0};
    end
    if (cmd.mul_lo) begin
      p_lo <= mul_p[31:0];
    end
    if (cmd.mul_hi) begin
      p_hi <= mul_p[34:0];
    end
  end

  // blend = alpha * d + acc * 2^32, then round to 1/128 degree
  logic signed [SumW-1:0] blend;
  logic signed [20:0]     f_wide;
  logic signed [15:0]     f_sat;

  assign blend = {{(SumW - 51){p_hi[34]}}, p_hi, 16'b0}
               + {{(SumW - 32){1'b0}}, p_lo}
               + {{(SumW - 48){acc[15]}}, acc, 32'b0}
               + (SumW'(1) <<< 31);
  assign f_wide = blend[SumW-1:32];

  always_comb begin
    if (f_wide > 21'sd32767) begin
      f_sat = 16'sh7FFF;
    end else if (f_wide < -21'sd32768) begin
      f_sat = 16'sh8000;
    end else begin
      f_sat = f_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
    end else if (cmd.finish) begin
      est <= f_sat;
    end
  end

  logic        out_valid;
  logic [31:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {f_sat, acc};
    end
  end

  assign status.out_busy = out_valid && !m_tready;
  assign m_tvalid        = out_valid;
  assign m_tdata         = out_data;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !m_tready))
    else $error("result register written while a result still waits");

  // a result appears only after a writeback
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without writeback");

  // the accelerometer angle stays inside a half turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data[15:0]) <= AngleLimit)
               && ($signed(out_data[15:0]) >= -AngleLimit))
    else $error("accelerometer angle out of range");

  // the estimate changes only at writeback
  a_est_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(est))
    else $error("angle estimate changed outside writeback");

endmodule

`default_nettype wire

// ===== hdl/complementary_tilt_filter.sv =====
// Top level of the complementary tilt filter: sequencer plus datapath.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    s_tdata: gyro_rate_raw, accel_x_raw, accel_z_raw
//  m_       out        m_tvalid/m_tready    m_tdata: accel_angle, fused_angle
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (0 alpha, 1 gyro_step_gain)
//
// A sample passes from accept to result through these steps: the accept, CordicIters
// CORDIC micro-rotations on the shared shift/add unit, angle rounding with rate times
// gain on the shared 18x18 multiplier, the difference, the two halves of alpha times that
// difference on the same multiplier, and a writeback that waits while a result is untaken.
// Reset sets alpha to 64225, gyro_step_gain to 734 and the angle estimate to zero.
// A waiting result does not block the next accept; it holds only the writeback step.
`default_nettype none

module complementary_tilt_filter
  import ctf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [47:0]        s_tdata,   // [15:0] gyro_rate_raw, [31:16] accel_x_raw,
                                             // [47:32] accel_z_raw
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [31:0]             m_tdata,   // [15:0] accel_angle, [31:16] fused_angle
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]        cfg_data
);

  ctf_cmd_t         cmd;
  ctf_status_t      status;
  logic [IterW-1:0] iter_idx;

  assign cfg_ready = 1'b1;

  ctf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd),
    .iter_idx (iter_idx)
  );

  ctf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .iter_idx  (iter_idx),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
